// File: rtl/assert_macros.svh
// Assertion helpers, included by the files that check themselves.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/cstl_pkg.sv
`timescale 1ns / 1ps

package cstl_pkg;

  localparam int ENTRIES_DEF = 4;
  localparam int KEY_W       = 32;
  localparam int TIME_W      = 32;
  localparam int SLOT_W      = 6;

  typedef enum logic [1:0] {
    OC_HIT   = 2'd0,
    OC_FILL  = 2'd1,
    OC_EVICT = 2'd2
  } outcome_t;

  // Read request into the entry store.
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] idx;
  } cstl_rd_req_t;

  // Registered read data out of the entry store.
  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] stamp;
  } cstl_rd_t;

  // Write of one entry; a write always marks the entry valid.
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] idx;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] stamp;
  } cstl_wr_t;

  // Control of the scan unit.
  typedef struct packed {
    logic              clear;
    logic              step;
    logic [SLOT_W-1:0] idx;
  } cstl_scan_ctl_t;

  // What the scan found after walking all entries.
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_idx;
    logic              empty_found;
    logic [SLOT_W-1:0] empty_idx;
    logic [SLOT_W-1:0] oldest_idx;
  } cstl_scan_res_t;

endpackage

// File: rtl/cstl_if.sv
`timescale 1ns / 1ps

interface cstl_req_if;
  import cstl_pkg::*;

  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  client_key;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, output client_key, output now_ms, input ready);
  modport sink (input valid, input client_key, input now_ms, output ready);
endinterface

interface cstl_rsp_if;
  import cstl_pkg::*;

  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot;
  logic [1:0]        outcome;

  modport source (output valid, output slot, output outcome, input ready);
  modport sink (input valid, input slot, input outcome, output ready);
endinterface

// File: rtl/client_slot_table_lru_top.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel  Direction  Word contents
// -------  ---------  ------------------------------------------
// req      in         client_key (32 bits), now_ms (32 bits)
// rsp      out        slot (6 bits), outcome (2 bits)
//
// Each accepted word is answered after a walk over all entries at one entry a cycle
// through the single read port of the entry store and the shared compare unit,
// followed by a commit step that loads the output register.
// Reset clears all valid bits at once; there is no clearing pass.
// A stalled response holds the block in its commit step until it is taken.

module client_slot_table_lru_top #(
  parameter int ENTRIES = cstl_pkg::ENTRIES_DEF
) (
  input logic       clk,
  input logic       rst,
  cstl_req_if.sink  req,
  cstl_rsp_if.source rsp
);
  import cstl_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  state_t            state;
  logic [KEY_W-1:0]  key_q;
  logic [TIME_W-1:0] now_q;
  logic [IDX_W-1:0]  rd_idx;
  logic              issue_done;
  logic              proc_en;
  logic [IDX_W-1:0]  proc_idx;
  logic              out_valid;
  logic [SLOT_W-1:0] out_slot;
  outcome_t          out_code;

  logic              accept;
  logic              out_free;
  logic [SLOT_W-1:0] pick;
  outcome_t          code;
  logic              code_ok;

  cstl_rd_req_t   rd_req;
  cstl_rd_t       rd;
  cstl_wr_t       wr;
  cstl_scan_ctl_t scan_ctl;
  cstl_scan_res_t scan_res;

  // A new request is taken only while no lookup is in progress.
  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;

  // The output register is free when empty or when its word leaves now.
  assign out_free = !out_valid || rsp.ready;

  // Reads are issued for entries 0 to ENTRIES-1; the data of each read is
  // scored in the next cycle, when it comes out of the store's read register.
  assign rd_req.en  = (state == ST_SCAN) && !issue_done;
  assign rd_req.idx = SLOT_W'(rd_idx);

  assign scan_ctl.clear = accept;
  assign scan_ctl.step  = proc_en;
  assign scan_ctl.idx   = SLOT_W'(proc_idx);

  // A hit wins over an empty slot, and an empty slot over eviction.
  always_comb begin
    if (scan_res.hit) begin
      pick = scan_res.hit_idx;
      code = OC_HIT;
    end else if (scan_res.empty_found) begin
      pick = scan_res.empty_idx;
      code = OC_FILL;
    end else begin
      pick = scan_res.oldest_idx;
      code = OC_EVICT;
    end
  end

  // On a hit the same key is written back with the fresh stamp.
  assign wr.en    = (state == ST_COMMIT) && out_free;
  assign wr.idx   = pick;
  assign wr.key   = key_q;
  assign wr.stamp = now_q;

  cstl_store #(
    .ENTRIES(ENTRIES)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .rd_req (rd_req),
    .rd     (rd),
    .wr     (wr)
  );

  cstl_scan #(
    .ENTRIES(ENTRIES)
  ) u_scan (
    .clk (clk),
    .rst (rst),
    .ctl (scan_ctl),
    .key (key_q),
    .now (now_q),
    .rd  (rd),
    .res (scan_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      issue_done <= 1'b0;
      proc_en    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      proc_en  <= rd_req.en;
      proc_idx <= rd_idx;
      // A commit loads the output register; otherwise a taken word empties it.
      if ((state == ST_COMMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            key_q      <= req.client_key;
            now_q      <= req.now_ms;
            rd_idx     <= '0;
            issue_done <= 1'b0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_req.en) begin
            if (rd_idx == LAST) begin
              issue_done <= 1'b1;
            end else begin
              rd_idx <= rd_idx + 1'b1;
            end
          end
          // The scan result is complete once the last entry is scored.
          if (proc_en && (proc_idx == LAST)) begin
            state <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (out_free) begin
            out_slot  <= pick;
            out_code  <= code;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.slot    = out_slot;
  assign rsp.outcome = out_code;

  assign code_ok = (rsp.outcome == OC_HIT) || (rsp.outcome == OC_FILL) ||
                   (rsp.outcome == OC_EVICT);

  // Every accepted request starts a walk over the entries.
  `ASSERT_NEXT(a_accept_starts_scan, accept, state == ST_SCAN)

  // A response appears only as the result of a commit step.
  `ASSERT_SAME(a_rsp_from_commit, $rose(rsp.valid), $past(state) == ST_COMMIT)

  // Only the three defined outcome codes are ever shown.
  `ASSERT_SAME(a_outcome_code, rsp.valid, code_ok)

endmodule

// File: rtl/cstl_store.sv
`timescale 1ns / 1ps

module cstl_store #(
  parameter int ENTRIES = cstl_pkg::ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cstl_pkg::cstl_rd_req_t rd_req,
  output cstl_pkg::cstl_rd_t     rd,
  input  cstl_pkg::cstl_wr_t     wr
);
  import cstl_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [KEY_W-1:0]  key_mem   [ENTRIES];
  logic [TIME_W-1:0] stamp_mem [ENTRIES];
  logic [ENTRIES-1:0] valid;

  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] wr_idx;

  assign rd_idx = rd_req.idx[IDX_W-1:0];
  assign wr_idx = wr.idx[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      key_mem[wr_idx]   <= wr.key;
      stamp_mem[wr_idx] <= wr.stamp;
    end
    if (rd_req.en) begin
      rd.key   <= key_mem[rd_idx];
      rd.stamp <= stamp_mem[rd_idx];
      rd.valid <= valid[rd_idx];
    end
  end

endmodule

// File: rtl/cstl_scan.sv
`timescale 1ns / 1ps

module cstl_scan #(
  parameter int ENTRIES = cstl_pkg::ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cstl_pkg::cstl_scan_ctl_t    ctl,
  input  logic [cstl_pkg::KEY_W-1:0]  key,
  input  logic [cstl_pkg::TIME_W-1:0] now,
  input  cstl_pkg::cstl_rd_t          rd,
  output cstl_pkg::cstl_scan_res_t    res
);
  import cstl_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic              hit;
  logic [IDX_W-1:0]  hit_idx;
  logic              empty_found;
  logic [IDX_W-1:0]  empty_idx;
  logic [TIME_W-1:0] oldest_age;
  logic [IDX_W-1:0]  oldest_idx;

  logic              match;
  logic [TIME_W-1:0] age;
  logic [IDX_W-1:0]  idx;

  // The one compare unit: key equality, wrapping age and age ordering.
  assign idx   = ctl.idx[IDX_W-1:0];
  assign match = rd.valid && (rd.key == key);
  assign age   = now - rd.stamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit         <= 1'b0;
      empty_found <= 1'b0;
    end else if (ctl.clear) begin
      hit         <= 1'b0;
      empty_found <= 1'b0;
      oldest_age  <= '0;
      oldest_idx  <= '0;
    end else if (ctl.step) begin
      if (match && !hit) begin
        hit     <= 1'b1;
        hit_idx <= idx;
      end
      if (!rd.valid && !empty_found) begin
        empty_found <= 1'b1;
        empty_idx   <= idx;
      end
      // Strictly greater, so ties stay with the lower index.
      if (age > oldest_age) begin
        oldest_age <= age;
        oldest_idx <= idx;
      end
    end
  end

  assign res.hit         = hit;
  assign res.hit_idx     = SLOT_W'(hit_idx);
  assign res.empty_found = empty_found;
  assign res.empty_idx   = SLOT_W'(empty_idx);
  assign res.oldest_idx  = SLOT_W'(oldest_idx);

endmodule

// File: test/tb_client_slot_table_lru_top.sv
`timescale 1ns / 1ps

// Testbench for the client slot table. Request words carry a client address
// and a millisecond time stamp; every request word produces exactly one
// response word with the slot that now holds the client and how it got there
// (hit, fill of an empty slot, or eviction of the oldest entry).
//
// A behavioral copy of the table lives in this module. Each request word that
// the block accepts is run through that copy, and the predicted response is
// queued. Each response word that the block hands over is compared, field by
// field, against the oldest queued prediction.

module tb_client_slot_table_lru_top;
  import cstl_pkg::*;

  localparam int TABLE_DEPTH = ENTRIES_DEF;
  // The final wait covers a full lookup, with slack on top.
  localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_LIMIT = 5000;
  localparam int RANDOM_WORDS = 600;
  localparam int POOL_SIZE = 6;
  localparam int IDLE_PERCENT = 37;

  typedef struct {
    logic [SLOT_W-1:0] slot;
    outcome_t          outcome;
  } slot_result_t;

  logic clk;
  logic rst;

  cstl_req_if req_ch ();
  cstl_rsp_if rsp_ch ();

  client_slot_table_lru_top #(
    .ENTRIES(TABLE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Shadow copy of the table, updated in acceptance order.
  logic [KEY_W-1:0]  shadow_key[TABLE_DEPTH];
  logic [TIME_W-1:0] shadow_stamp[TABLE_DEPTH];
  bit                shadow_used[TABLE_DEPTH];

  slot_result_t pending_slots[$];

  int err_count = 0;
  int cycle_count = 0;
  int words_sent = 0;
  int words_checked = 0;
  int hit_count = 0;
  int fill_count = 0;
  int evict_count = 0;

  // When steady is set, neither side inserts idle cycles.
  bit steady = 0;
  // Number of cycles the response side still has to hold ready low.
  int rsp_hold_left = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d responses outstanding",
               cycle_count, pending_slots.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    err_count++;
  endtask

  // Behavioral table lookup. A matching valid entry is refreshed; otherwise
  // the lowest empty slot is filled; otherwise the entry with the largest
  // wrapping age is replaced, ties going to the lowest index.
  function automatic slot_result_t lookup_client(input logic [KEY_W-1:0] key,
                                                 input logic [TIME_W-1:0] now);
    slot_result_t      res;
    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] oldest;
    int                pick;
    bit                found;

    found = 0;
    pick = 0;
    res.outcome = OC_HIT;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!found && shadow_used[i] && shadow_key[i] == key) begin
        shadow_stamp[i] = now;
        pick = i;
        found = 1;
      end
    end
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!found && !shadow_used[i]) begin
        pick = i;
        res.outcome = OC_FILL;
        found = 1;
      end
    end
    if (!found) begin
      oldest = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        age = now - shadow_stamp[i];
        if (age > oldest) begin
          oldest = age;
          pick = i;
        end
      end
      res.outcome = OC_EVICT;
    end
    if (res.outcome != OC_HIT) begin
      shadow_key[pick] = key;
      shadow_stamp[pick] = now;
      shadow_used[pick] = 1;
    end
    res.slot = SLOT_W'(pick);
    return res;
  endfunction

  // Both channels are sampled at the rising edge. A response is checked before
  // the request of the same edge is predicted, since it can only belong to an
  // earlier request.
  always @(posedge clk) begin
    slot_result_t want;
    if (rst) begin
      for (int i = 0; i < TABLE_DEPTH; i++)
        shadow_used[i] = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_slots.size() == 0) begin
          report_mismatch($sformatf("response word with nothing expected, slot %0d outcome %0d",
                                    rsp_ch.slot, rsp_ch.outcome));
        end else begin
          want = pending_slots.pop_front();
          words_checked++;
          if (rsp_ch.slot !== want.slot)
            report_mismatch($sformatf("slot is %0d, expected %0d", rsp_ch.slot, want.slot));
          if (rsp_ch.outcome !== want.outcome)
            report_mismatch($sformatf("outcome is %0d, expected %0d (%s)",
                                      rsp_ch.outcome, want.outcome, want.outcome.name()));
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        want = lookup_client(req_ch.client_key, req_ch.now_ms);
        pending_slots.push_back(want);
        words_sent++;
        case (want.outcome)
          OC_HIT:  hit_count++;
          OC_FILL: fill_count++;
          default: evict_count++;
        endcase
      end
    end
  end

  // Response side. A requested hold keeps ready low for a counted stretch;
  // otherwise ready drops at random unless the steady stretch is running.
  initial begin
    rsp_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (rsp_hold_left > 0) begin
        rsp_ch.ready <= 0;
        rsp_hold_left--;
      end else if (steady) begin
        rsp_ch.ready <= 1;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Offers one request word and returns once it has been taken. Random idle
  // cycles go in front of the word; valid is only lowered during those, so a
  // back-to-back word keeps valid high across the boundary.
  task automatic send_request(input logic [KEY_W-1:0] key, input logic [TIME_W-1:0] now);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      @(negedge clk);
      req_ch.valid <= 0;
    end
    @(negedge clk);
    req_ch.valid <= 1;
    req_ch.client_key <= key;
    req_ch.now_ms <= now;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Stops offering words until every predicted response has been seen.
  task automatic wait_for_drain();
    int waited;
    waited = 0;
    @(negedge clk);
    req_ch.valid <= 0;
    while (pending_slots.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // Fills the empty table from the lowest slot up, using the extreme key and
  // time values, and mixes in hits on entries already present.
  task automatic test_fill_and_hit();
    send_request(32'h0000_0000, 32'h0000_0000);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'h1234_5678, 32'd10);
    send_request(32'hFFFF_FFFF, 32'd20);
    send_request(32'hA5A5_A5A5, 32'd20);
    send_request(32'h0000_0000, 32'd30);
  endtask

  // Every entry is stamped with the same time. A new client at that very time
  // sees all ages zero, and one at a later time sees all ages equal and
  // nonzero; both must evict slot 0.
  task automatic test_equal_ages();
    send_request(32'h0000_0000, 32'd1000);
    send_request(32'hFFFF_FFFF, 32'd1000);
    send_request(32'h1234_5678, 32'd1000);
    send_request(32'hA5A5_A5A5, 32'd1000);
    send_request(32'h1111_1111, 32'd1000);
    send_request(32'h2222_2222, 32'd5000);
  endtask

  // Time running backwards makes a stamp ahead of the current time look very
  // old; the counter wrapping from its top value to zero is also covered.
  task automatic test_time_wrap();
    send_request(32'hFFFF_FFFF, 32'd900);
    send_request(32'h3333_3333, 32'd950);
    send_request(32'h4444_4444, 32'hFFFF_FFFF);
    send_request(32'h5555_5555, 32'h0000_0000);
  endtask

  // Distinct stamps: the entry touched longest ago must be the victim, even
  // when it sits in the highest slot.
  task automatic test_evict_oldest();
    send_request(32'h6666_6666, 32'd100);
    send_request(32'h7777_7777, 32'd200);
    send_request(32'h8888_8888, 32'd300);
    send_request(32'h9999_9999, 32'd400);
  endtask

  // The response side holds off for a long counted stretch while the request
  // side keeps offering words back to back, so the block fills up and has to
  // stall its input. Afterwards everything must drain in order.
  task automatic test_output_stall();
    steady = 1;
    rsp_hold_left = 300;
    for (int n = 0; n < 12; n++)
      send_request(KEY_W'($urandom_range(7)), TIME_W'(6000 + 10 * n));
    steady = 0;
    wait_for_drain();
  endtask

  // Bulk traffic. Most words pick from a small pool of clients, larger than
  // the table, so hits, fills and evictions all keep happening; the rest use
  // arbitrary addresses. Time mostly moves forward in small steps, sometimes
  // stands still (creating age ties), leaps ahead, or jumps anywhere at all.
  // A stretch in the middle runs with no idling on either side, and the
  // request side now and then pauses until all responses are back.
  task automatic test_random_traffic();
    logic [KEY_W-1:0]  client_pool[POOL_SIZE];
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] clock_ms;
    int                roll;

    for (int i = 0; i < POOL_SIZE; i++)
      client_pool[i] = $urandom();
    clock_ms = $urandom();
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == 200)
        steady = 1;
      if (n == 320)
        steady = 0;
      if (n % 150 == 149)
        wait_for_drain();
      if ($urandom_range(99) < 80)
        key = client_pool[$urandom_range(POOL_SIZE - 1)];
      else
        key = $urandom();
      roll = $urandom_range(99);
      if (roll < 10)
        clock_ms = clock_ms;
      else if (roll < 85)
        clock_ms = clock_ms + $urandom_range(1, 40);
      else if (roll < 95)
        clock_ms = clock_ms + $urandom_range(1000, 100000);
      else
        clock_ms = $urandom();
      send_request(key, clock_ms);
    end
  endtask

  initial begin
    // Every input starts at a known value; reset is held before the tests start.
    rst = 1;
    req_ch.valid = 0;
    req_ch.client_key = '0;
    req_ch.now_ms = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    test_fill_and_hit();
    test_equal_ages();
    test_time_wrap();
    test_evict_oldest();
    test_output_stall();
    test_random_traffic();

    // Drain the last responses, then give the block time to show any stray
    // word it should not produce.
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_slots.size() != 0)
      report_mismatch($sformatf("%0d expected responses never arrived", pending_slots.size()));

    $display("Run covered %0d request words and %0d checked responses in %0d cycles.",
             words_sent, words_checked, cycle_count);
    $display("Outcomes seen: %0d hits, %0d fills, %0d evictions; %0d mismatches.",
             hit_count, fill_count, evict_count, err_count);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/cstl_pkg.sv
rtl/cstl_if.sv
rtl/cstl_store.sv
rtl/cstl_scan.sv
rtl/client_slot_table_lru_top.sv
test/tb_client_slot_table_lru_top.sv
